// ===== src/b64enc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the symbol map of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

   localparam int MAX_CHARS     = 6;
   localparam int CNT_W         = $clog2(MAX_CHARS + 1);
   localparam int IDX_W         = $clog2(MAX_CHARS);
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] CHAR_PAD = 8'h3d;  // '='
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_UC  = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_LC  = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_DIG = 8'h30;  // '0'
   localparam logic [7:0] CHAR_PLS = 8'h2b;  // '+'
   localparam logic [7:0] CHAR_SLS = 8'h2f;  // '/'

   // characters one input beat expands to, oldest in slot 0
   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;
      logic [CNT_W-1:0]          count;
      logic                      ends;   // job closes the message with CR LF
   } job_type;

   function automatic logic [7:0] sym_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26) begin
         sym_char = CHAR_UC + w;
      end else if (v < 6'd52) begin
         sym_char = CHAR_LC + w - 8'd26;
      end else if (v < 6'd62) begin
         sym_char = CHAR_DIG + w - 8'd52;
      end else if (v == 6'd62) begin
         sym_char = CHAR_PLS;
      end else begin
         sym_char = CHAR_SLS;
      end
   endfunction

endpackage

// ===== src/base64_stream_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming base64 encoder: raw bytes in, base64 characters, padding and
// CR LF out, one character per beat.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  req       in         req_push/full    data_byte, has_byte, end_of_input
//  rsp       out        rsp_pop/empty    out_char, last_char
//
//  Input beats are taken one per cycle while the job queue has room; a beat
//  turns into up to six characters, and the output side hands out one
//  character per cycle while rsp_pop is held. A beat's first character goes
//  through the job queue and then the back end's current-job register.
//  Synchronous reset clears phase, queue and output state.
//  Either side may stall; the job queue decouples the two.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_data_byte,
   input  logic       req_has_byte,
   input  logic       req_end_of_input,
   input  logic       req_push,
   output logic       req_full,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char,
   output logic       rsp_empty,
   input  logic       rsp_pop
);

   b64enc_pkg::job_type push_job, pop_job;
   logic job_push, job_full, job_pop, job_empty;

   b64enc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_end_of_input (req_end_of_input),
      .req_push         (req_push),
      .req_full         (req_full),
      .job_push         (job_push),
      .job_data         (push_job),
      .job_full         (job_full)
   );

   b64enc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .empty     (job_empty)
   );

   b64enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_data      (pop_job),
      .job_empty     (job_empty),
      .job_pop       (job_pop),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop)
   );

endmodule

// ===== src/b64enc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts input beats, tracks group phase and leftover bits, and turns each
// beat into a job of up to six characters for the back end.
// ----------------------------------------------------------------------------
module b64enc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_data_byte,
   input  logic                req_has_byte,
   input  logic                req_end_of_input,
   input  logic                req_push,
   output logic                req_full,
   output logic                job_push,
   output b64enc_pkg::job_type job_data,
   input  logic                job_full
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic       accept;
   logic [1:0] ph;
   logic [3:0] lf;
   logic [b64enc_pkg::CNT_W-1:0] n;
   b64enc_pkg::job_type job;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   always_comb begin
      job  = '0;
      n    = '0;
      ph   = (phase_ff == 2'd3) ? 2'd0 : phase_ff;
      lf   = left_ff;
      if (req_has_byte) begin
         unique case (ph)
            2'd0: begin
               job.chars[0] = b64enc_pkg::sym_char(req_data_byte[7:2]);
               n  = b64enc_pkg::CNT_W'(1);
               lf = {2'b00, req_data_byte[1:0]};
               ph = 2'd1;
            end
            2'd1: begin
               job.chars[0] = b64enc_pkg::sym_char({lf[1:0], req_data_byte[7:4]});
               n  = b64enc_pkg::CNT_W'(1);
               lf = req_data_byte[3:0];
               ph = 2'd2;
            end
            default: begin
               job.chars[0] = b64enc_pkg::sym_char({lf, req_data_byte[7:6]});
               job.chars[1] = b64enc_pkg::sym_char(req_data_byte[5:0]);
               n  = b64enc_pkg::CNT_W'(2);
               lf = 4'd0;
               ph = 2'd0;
            end
         endcase
      end
      if (req_end_of_input) begin
         if (ph == 2'd1) begin
            job.chars[n[b64enc_pkg::IDX_W-1:0]] = b64enc_pkg::sym_char({lf[1:0], 4'd0});
            job.chars[n[b64enc_pkg::IDX_W-1:0] + 1'b1] = b64enc_pkg::CHAR_PAD;
            job.chars[n[b64enc_pkg::IDX_W-1:0] + 2'd2] = b64enc_pkg::CHAR_PAD;
            n = n + b64enc_pkg::CNT_W'(3);
         end else if (ph == 2'd2) begin
            job.chars[n[b64enc_pkg::IDX_W-1:0]] = b64enc_pkg::sym_char({lf, 2'd0});
            job.chars[n[b64enc_pkg::IDX_W-1:0] + 1'b1] = b64enc_pkg::CHAR_PAD;
            n = n + b64enc_pkg::CNT_W'(2);
         end
         job.chars[n[b64enc_pkg::IDX_W-1:0]] = b64enc_pkg::CHAR_CR;
         job.chars[n[b64enc_pkg::IDX_W-1:0] + 1'b1] = b64enc_pkg::CHAR_LF;
         n  = n + b64enc_pkg::CNT_W'(2);
         lf = 4'd0;
         ph = 2'd0;
         job.ends = 1'b1;
      end
      job.count = n;
      phase_in  = ph;
      left_in   = lf;
   end

   // a bare beat without end carries no characters and is dropped here
   assign job_push = accept && (job.count != '0);
   assign job_data = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         left_ff  <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ===== src/b64enc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_fifo
// Short register queue of character jobs between the front and back ends.
// ----------------------------------------------------------------------------
module b64enc_fifo #(
   parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64enc_pkg::job_type push_data,
   output logic                full,
   input  logic                pop,
   output b64enc_pkg::job_type pop_data,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64enc_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== src/b64enc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_back
// Holds the current job and hands its characters out one beat at a time.
// ----------------------------------------------------------------------------
module b64enc_back (
   input  logic                clock,
   input  logic                reset,
   input  b64enc_pkg::job_type job_data,
   input  logic                job_empty,
   output logic                job_pop,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_last_char,
   output logic                rsp_empty,
   input  logic                rsp_pop
);

   b64enc_pkg::job_type cur_ff;
   logic [b64enc_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic busy_ff, busy_in;
   logic at_last, take, load;

   assign at_last = (b64enc_pkg::CNT_W'(idx_ff) + 1'b1) == cur_ff.count;
   assign take    = rsp_pop && busy_ff;
   // next job is loaded in the same cycle the last character of this one leaves
   assign job_pop = !busy_ff || (take && at_last);
   assign load    = job_pop && !job_empty;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (take && at_last) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= job_data;
      end
   end

   assign rsp_empty     = !busy_ff;
   assign rsp_out_char  = cur_ff.chars[idx_ff];
   assign rsp_last_char = cur_ff.ends && at_last;

endmodule
